// File: rtl/core/positional_list_store_macros.svh
// Assertion macros used by the positional list store top level.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PLS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list store check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list store check failed");

`endif

// File: rtl/core/pls_pkg.sv
// Package with the codes, defaults and cell control type of the list store.
`timescale 1ns / 1ps
package pls_pkg;

  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_GET      = 3'd2,
    ACT_INDEX_OF = 3'd3,
    ACT_CLEAR    = 3'd4,
    ACT_FIRST    = 3'd5,
    ACT_LAST     = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISS    = 2'd3
  } status_t;

  typedef struct packed {
    logic take_key;
    logic take_prev;
    logic take_next;
  } cell_ctl_t;

endpackage

// File: rtl/core/positional_list_store.sv
// Top level of the positional list store: decoder, cell chain and result register.
`timescale 1ns / 1ps
`include "positional_list_store_macros.svh"
// Fixed-capacity ordered list of words held in a chain of cells.
// Request channel: req_valid/req_stall with action, position and value.
// Result channel: res_valid/res_stall with status, data_out, found_index,
// count, full_res and empty_res; exactly one result word per request word.
// Every action, including insert and remove with their shifts and the
// index-of search, finishes in the cycle it is accepted: each cell loads
// from its neighbor, the key or itself at that edge, and the search is a
// compare in every cell followed by a priority encoder.
// The result appears in the output register in the cycle after acceptance,
// and one request word is taken per cycle while req_stall is low.
// While a result waits under res_stall, req_stall is raised, so at most one
// result is ever pending; the next request is taken in the cycle the
// pending result leaves.
// Reset empties the list and clears the result valid; cell contents are
// not cleared and are never read before they are written.
module positional_list_store #(
  parameter int CAPACITY    = pls_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = pls_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  action,
  input  logic [5:0]  position,
  input  logic [31:0] value,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [31:0] data_out,
  output logic [4:0]  found_index,
  output logic [5:0]  count,
  output logic        full_res,
  output logic        empty_res
);
  import pls_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  logic [CNT_W-1:0]       fill_count;
  logic [CNT_W-1:0]       fill_count_next;
  logic                   accept;
  action_t                act;
  status_t                st;
  logic [CMP_W-1:0]       pos_c;
  logic [CMP_W-1:0]       cnt_c;
  logic [CMP_W-1:0]       rd_c;
  logic                   is_full;
  logic                   is_empty;
  logic                   ins_ok;
  logic                   rem_ok;
  logic                   rd_en;
  logic                   srch;
  logic [VALUE_WIDTH-1:0] key;
  logic [VALUE_WIDTH-1:0] words [CAPACITY];
  logic [VALUE_WIDTH-1:0] prev_w [CAPACITY];
  logic [VALUE_WIDTH-1:0] next_w [CAPACITY];
  cell_ctl_t              ctl [CAPACITY];
  logic [CAPACITY-1:0]    match_raw;
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    rd_sel;
  logic [VALUE_WIDTH-1:0] rd_word;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;

  assign req_stall = res_valid & res_stall;
  assign accept    = req_valid & ~req_stall;
  assign act       = action_t'(action);
  assign key       = VALUE_WIDTH'(value);
  assign pos_c     = CMP_W'(position);
  assign cnt_c     = CMP_W'(fill_count);
  assign is_full   = (fill_count == CNT_W'(CAPACITY));
  assign is_empty  = (fill_count == '0);

  always_comb begin
    st              = ST_OK;
    ins_ok          = 1'b0;
    rem_ok          = 1'b0;
    rd_en           = 1'b0;
    srch            = 1'b0;
    rd_c            = pos_c;
    fill_count_next = fill_count;
    unique case (act)
      ACT_INSERT: begin
        if (pos_c > cnt_c) begin
          st = ST_BAD_POS;
        end else if (is_full) begin
          st = ST_FULL;
        end else begin
          ins_ok          = 1'b1;
          fill_count_next = fill_count + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (pos_c >= cnt_c) begin
          st = ST_BAD_POS;
        end else begin
          rem_ok          = 1'b1;
          rd_en           = 1'b1;
          fill_count_next = fill_count - CNT_W'(1);
        end
      end
      ACT_GET: begin
        if (is_empty) begin
          st = ST_MISS;
        end else if (pos_c >= cnt_c) begin
          st = ST_BAD_POS;
        end else begin
          rd_en = 1'b1;
        end
      end
      ACT_INDEX_OF: begin
        srch = 1'b1;
        if (!hit) begin
          st = ST_MISS;
        end
      end
      ACT_CLEAR: begin
        fill_count_next = '0;
      end
      ACT_FIRST: begin
        rd_c = '0;
        if (is_empty) begin
          st = ST_MISS;
        end else begin
          rd_en = 1'b1;
        end
      end
      ACT_LAST: begin
        rd_c = cnt_c - CMP_W'(1);
        if (is_empty) begin
          st = ST_MISS;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(g);

    if (g == 0) begin : g_first
      assign prev_w[g] = key;
    end else begin : g_mid
      assign prev_w[g] = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w[g] = words[g];
    end else begin : g_inner
      assign next_w[g] = words[g+1];
    end

    assign ctl[g].take_key  = accept & ins_ok & (IDX == pos_c);
    assign ctl[g].take_prev = accept & ins_ok & (IDX > pos_c);
    assign ctl[g].take_next = accept & rem_ok & (IDX >= pos_c);
    assign match[g]         = match_raw[g] & (IDX < cnt_c);
    assign rd_sel[g]        = (IDX == rd_c);

    pls_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .key      (key),
      .prev_word(prev_w[g]),
      .next_word(next_w[g]),
      .word     (words[g]),
      .match    (match_raw[g])
    );
  end

  pls_gather #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_gather (
    .words  (words),
    .rd_sel (rd_sel),
    .match  (match),
    .rd_word(rd_word),
    .hit    (hit),
    .hit_idx(hit_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
        res_valid  <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= st;
      data_out    <= rd_en ? 32'(rd_word) : '0;
      found_index <= (srch && hit) ? 5'(hit_idx) : '0;
      count       <= 6'(fill_count_next);
      full_res    <= (fill_count_next == CNT_W'(CAPACITY));
      empty_res   <= (fill_count_next == '0);
    end
  end

  `PLS_ASSERT_SAME(a_count_in_range, clk, rst, 1'b1, fill_count <= CNT_W'(CAPACITY))
  `PLS_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, res_valid)
  `PLS_ASSERT_NEXT(a_clear_empties, clk, rst, accept && (act == ACT_CLEAR), is_empty && empty_res)
  `PLS_ASSERT_SAME(a_error_has_no_data, clk, rst, res_valid && (status != ST_OK), data_out == '0)

endmodule

// File: rtl/core/pls_cell.sv
// One storage cell of the list chain: holds a word and trades it with its neighbors.
`timescale 1ns / 1ps
module pls_cell #(
  parameter int VALUE_WIDTH = pls_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  pls_pkg::cell_ctl_t     ctl,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [VALUE_WIDTH-1:0] prev_word,
  input  logic [VALUE_WIDTH-1:0] next_word,
  output logic [VALUE_WIDTH-1:0] word,
  output logic                   match
);
  import pls_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.take_key) begin
      word <= key;
    end else if (ctl.take_prev) begin
      word <= prev_word;
    end else if (ctl.take_next) begin
      word <= next_word;
    end
  end

  assign match = (word == key);

endmodule

// File: rtl/core/pls_gather.sv
// Collects the chain outputs: the selected word and the lowest matching position.
`timescale 1ns / 1ps
module pls_gather #(
  parameter int CAPACITY    = pls_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = pls_pkg::VALUE_WIDTH_DEF,
  parameter int IDX_W       = 5
) (
  input  logic [VALUE_WIDTH-1:0] words [CAPACITY],
  input  logic [CAPACITY-1:0]    rd_sel,
  input  logic [CAPACITY-1:0]    match,
  output logic [VALUE_WIDTH-1:0] rd_word,
  output logic                   hit,
  output logic [IDX_W-1:0]       hit_idx
);
  import pls_pkg::*;

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | ({VALUE_WIDTH{rd_sel[i]}} & words[i]);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit = |match;

endmodule
